>>> rtl/core/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, codes and fixed-point helpers for the sparse polynomial unit.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int COEF_W      = 32;
  localparam int EXP_W       = 15;
  localparam int REXP_W      = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OP_W        = 3;
  localparam int STAT_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_TERM      = 2'd0,
    STAT_LOAD_OK   = 2'd1,
    STAT_LOAD_FULL = 2'd2,
    STAT_ZERO      = 2'd3
  } stat_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L_RD,
    S_L_CMP,
    S_L_INS,
    S_L_SH,
    S_L_SHW,
    S_L_DEL,
    S_L_DELW,
    S_RESP,
    S_P_RDB,
    S_P_LDB,
    S_M_RD,
    S_M_MUL,
    S_M_RND,
    S_M_EV,
    S_E_RD,
    S_E_OUT
  } st_e;

  // term table entry (A and B share one memory)
  typedef struct packed {
    logic [COEF_W-1:0] c;
    logic [EXP_W-1:0]  e;
  } tent_t;

  // result table entry
  typedef struct packed {
    logic [COEF_W-1:0] c;
    logic [REXP_W-1:0] e;
  } pent_t;

  localparam logic signed [COEF_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] Q_MIN = 32'sh8000_0000;

  function automatic logic [COEF_W-1:0] sat33(input logic signed [COEF_W:0] v);
    logic [COEF_W-1:0] r;
    if (v[COEF_W] != v[COEF_W-1]) r = v[COEF_W] ? Q_MIN : Q_MAX;
    else r = v[COEF_W-1:0];
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] sat48(input logic signed [47:0] v);
    logic [COEF_W-1:0] r;
    if (v > 48'sh0000_7FFF_FFFF) r = Q_MAX;
    else if (v < -48'sh0000_8000_0000) r = Q_MIN;
    else r = v[COEF_W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/core/sparse_polynomial_arithmetic.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_arithmetic
// Load: scans the table entries, then shifts entries to insert or delete one,
//   answered by one beat.
// Add/subtract: merge steps (at most |A|+|B|), then one beat per term out.
// Multiply: one merge pass per B term; paced by the single write port and
//   registered read of the term and result memories.
// Reset clears both table counts, the result bank select and the output
// valid flag; memories and output data registers keep data.
// ----------------------------------------------------------------------------
module sparse_polynomial_arithmetic #(
  parameter int MAX_TERMS    = 8,
  parameter int RESULT_TERMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // term_coefficient [31:0], term_exponent [46:32], zero pad [47]
  input  logic [spa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode [2:0]
  input  logic [spa_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_coefficient [31:0], result_exponent [47:32]
  output logic [spa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // status [1:0]
  output logic [spa_pkg::STAT_W-1:0]        m_axis_tuser
);
  import spa_pkg::*;

  localparam int CW     = $clog2(MAX_TERMS + 1);
  localparam int TAW    = $clog2(2 * MAX_TERMS);
  localparam int TDEPTH = 2 ** TAW;
  localparam int PB     = (RESULT_TERMS > 2 * MAX_TERMS) ? RESULT_TERMS : 2 * MAX_TERMS;
  localparam int PAW    = $clog2(PB);
  localparam int NW     = $clog2(PB + 1);
  localparam int PDEPTH = 2 ** (PAW + 1);

  function automatic logic [TAW-1:0] tab_addr(input logic sel, input logic [CW-1:0] idx);
    return sel ? TAW'(MAX_TERMS) + TAW'(idx) : TAW'(idx);
  endfunction

  // memories
  tent_t tab_mem [TDEPTH];
  pent_t prod_mem [PDEPTH];
  tent_t trd0_q, trd1_q, twd;
  pent_t prd_q, pwd;
  logic  twe, tre, pwe, pre;
  logic [TAW-1:0] twa, tra0, tra1;
  logic [PAW:0]   pwa, pra;

  st_e state_q, state_d;
  logic              tsel_q, tsel_d;
  logic [COEF_W-1:0] lc_q, lc_d;
  logic [EXP_W-1:0]  le_q, le_d;
  logic [CW-1:0]     li_q, li_d, lk_q, lk_d;
  logic [CW-1:0]     cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d, jb_q, jb_d;
  stat_e             stat_q, stat_d;
  logic              mul_q, mul_d, neg_q, neg_d, bank_q, bank_d;
  logic [NW-1:0]     xi_q, xi_d, yi_q, yi_d, mn_q, mn_d, xn_q, xn_d, yn_q, yn_d;
  logic [NW-1:0]     cap_q, cap_d, pc_q, pc_d, ek_q, ek_d;
  logic [COEF_W-1:0] bhc_q, bhc_d, xc_q, xc_d, yc_q, yc_d;
  logic [EXP_W-1:0]  bhe_q, bhe_d;
  logic [REXP_W-1:0] xe_q, xe_d, ye_q, ye_d;
  logic signed [63:0] prod_q, prod_d;

  logic              ovld_q;
  logic [COEF_W-1:0] ocoef_q, ocoef_d;
  logic [REXP_W-1:0] oexp_q, oexp_d;
  logic              olast_q, olast_d;
  stat_e             ostat_q, ostat_d;
  logic              oload;

  // shared decode
  logic              in_acc, ofree, x_av, y_av, take_x, take_both, l_gt, l_eq, ev_keep;
  logic [CW-1:0]     lcnt;
  logic [CW:0]       lk_inc;
  logic [COEF_W-1:0] l_sum, ev_sum, ev_c, neg_b, yc_mul;
  logic [REXP_W-1:0] ev_e;
  logic signed [63:0] mul_r;
  op_e               in_op;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_op     = op_e'(s_axis_tuser);
  assign ofree     = !ovld_q || m_axis_tready;
  assign lcnt      = tsel_q ? cnt_b_q : cnt_a_q;
  assign lk_inc    = {1'b0, lk_q} + 1'b1;
  assign l_gt      = $signed(trd0_q.e) > $signed(le_q);
  assign l_eq      = trd0_q.e == le_q;
  assign l_sum     = sat33($signed({trd0_q.c[COEF_W-1], trd0_q.c}) +
                           $signed({lc_q[COEF_W-1], lc_q}));
  assign x_av      = xi_q < xn_q;
  assign y_av      = yi_q < yn_q;
  assign take_x    = !y_av || (x_av && ($signed(xe_q) > $signed(ye_q)));
  assign take_both = x_av && y_av && (xe_q == ye_q);
  assign ev_sum    = sat33($signed({xc_q[COEF_W-1], xc_q}) + $signed({yc_q[COEF_W-1], yc_q}));
  assign ev_c      = take_x ? xc_q : (take_both ? ev_sum : yc_q);
  assign ev_e      = (take_x || take_both) ? xe_q : ye_q;
  assign ev_keep   = (ev_c != '0) && (mn_q < cap_q);
  assign neg_b     = sat33(33'sd0 - $signed({trd1_q.c[COEF_W-1], trd1_q.c}));
  assign mul_r     = prod_q + 64'sd32768;
  assign yc_mul    = sat48(mul_r[63:16]);

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {oexp_q, ocoef_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ostat_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_LOAD_A, OP_LOAD_B:
              state_d = (s_axis_tdata[COEF_W-1:0] == '0) ? S_RESP : S_L_RD;
            OP_ADD, OP_SUB: state_d = S_M_RD;
            OP_MUL:         state_d = S_P_RDB;
            default:        state_d = S_IDLE;
          endcase
        end
      end
      S_L_RD:   state_d = (li_q >= lcnt) ? S_L_INS : S_L_CMP;
      S_L_CMP: begin
        priority if (l_gt) state_d = S_L_RD;
        else if (l_eq)     state_d = (l_sum != '0) ? S_RESP : S_L_DEL;
        else               state_d = S_L_INS;
      end
      S_L_INS:  state_d = (lcnt >= CW'(MAX_TERMS)) ? S_RESP : S_L_SH;
      S_L_SH:   state_d = (lk_q == li_q) ? S_RESP : S_L_SHW;
      S_L_SHW:  state_d = S_L_SH;
      S_L_DEL:  state_d = (lk_inc >= {1'b0, lcnt}) ? S_RESP : S_L_DELW;
      S_L_DELW: state_d = S_L_DEL;
      S_RESP:   state_d = ofree ? S_IDLE : S_RESP;
      S_P_RDB:  state_d = (jb_q >= cnt_b_q) ? S_E_RD : S_P_LDB;
      S_P_LDB:  state_d = S_M_RD;
      S_M_RD: begin
        if (!x_av && !y_av) state_d = mul_q ? S_P_RDB : S_E_RD;
        else                state_d = mul_q ? S_M_MUL : S_M_RND;
      end
      S_M_MUL:  state_d = S_M_RND;
      S_M_RND:  state_d = S_M_EV;
      S_M_EV:   state_d = S_M_RD;
      S_E_RD:   state_d = S_E_OUT;
      S_E_OUT: begin
        if (ofree) begin
          if (pc_q == '0 || NW'(ek_q + 1'b1) == pc_q) state_d = S_IDLE;
          else state_d = S_E_RD;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    tsel_d = tsel_q;  lc_d = lc_q;  le_d = le_q;  li_d = li_q;  lk_d = lk_q;
    cnt_a_d = cnt_a_q;  cnt_b_d = cnt_b_q;  jb_d = jb_q;  stat_d = stat_q;
    mul_d = mul_q;  neg_d = neg_q;  bank_d = bank_q;
    xi_d = xi_q;  yi_d = yi_q;  mn_d = mn_q;  xn_d = xn_q;  yn_d = yn_q;
    cap_d = cap_q;  pc_d = pc_q;  ek_d = ek_q;
    bhc_d = bhc_q;  bhe_d = bhe_q;  xc_d = xc_q;  xe_d = xe_q;  yc_d = yc_q;  ye_d = ye_q;
    prod_d = prod_q;
    ocoef_d = ocoef_q;  oexp_d = oexp_q;  olast_d = olast_q;  ostat_d = ostat_q;  oload = 1'b0;
    twe = 1'b0;  twa = '0;  twd = '0;  tre = 1'b0;  tra0 = '0;  tra1 = '0;
    pwe = 1'b0;  pwa = '0;  pwd = '0;  pre = 1'b0;  pra = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          lc_d   = s_axis_tdata[COEF_W-1:0];
          le_d   = s_axis_tdata[COEF_W +: EXP_W];
          tsel_d = in_op == OP_LOAD_B;
          li_d   = '0;
          stat_d = STAT_LOAD_OK;
          xi_d   = '0;
          yi_d   = '0;
          mn_d   = '0;
          unique case (in_op)
            OP_ADD, OP_SUB: begin
              mul_d = 1'b0;
              neg_d = in_op == OP_SUB;
              xn_d  = NW'(cnt_a_q);
              yn_d  = NW'(cnt_b_q);
              cap_d = NW'(PB);
            end
            OP_MUL: begin
              mul_d = 1'b1;
              neg_d = 1'b0;
              pc_d  = '0;
              jb_d  = '0;
            end
            OP_CLEAR: begin
              cnt_a_d = '0;
              cnt_b_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_L_RD: begin
        tre  = 1'b1;
        tra0 = tab_addr(tsel_q, li_q);
      end
      S_L_CMP: begin
        priority if (l_gt) begin
          li_d = li_q + 1'b1;
        end else if (l_eq) begin
          if (l_sum != '0) begin
            twe = 1'b1;
            twa = tab_addr(tsel_q, li_q);
            twd = '{c: l_sum, e: le_q};
          end else begin
            lk_d = li_q;
          end
        end else begin
          lk_d = li_q;
        end
      end
      S_L_INS: begin
        if (lcnt >= CW'(MAX_TERMS)) stat_d = STAT_LOAD_FULL;
        else lk_d = lcnt;
      end
      S_L_SH: begin
        if (lk_q == li_q) begin
          twe = 1'b1;
          twa = tab_addr(tsel_q, li_q);
          twd = '{c: lc_q, e: le_q};
          if (tsel_q) cnt_b_d = cnt_b_q + 1'b1;
          else        cnt_a_d = cnt_a_q + 1'b1;
        end else begin
          tre  = 1'b1;
          tra0 = tab_addr(tsel_q, lk_q - 1'b1);
        end
      end
      S_L_SHW: begin
        twe  = 1'b1;
        twa  = tab_addr(tsel_q, lk_q);
        twd  = trd0_q;
        lk_d = lk_q - 1'b1;
      end
      S_L_DEL: begin
        if (lk_inc >= {1'b0, lcnt}) begin
          if (tsel_q) cnt_b_d = cnt_b_q - 1'b1;
          else        cnt_a_d = cnt_a_q - 1'b1;
        end else begin
          tre  = 1'b1;
          tra0 = tab_addr(tsel_q, lk_inc[CW-1:0]);
        end
      end
      S_L_DELW: begin
        twe  = 1'b1;
        twa  = tab_addr(tsel_q, lk_q);
        twd  = trd0_q;
        lk_d = lk_inc[CW-1:0];
      end
      S_RESP: begin
        if (ofree) begin
          oload   = 1'b1;
          ocoef_d = '0;
          oexp_d  = '0;
          olast_d = 1'b1;
          ostat_d = stat_q;
        end
      end
      S_P_RDB: begin
        if (jb_q >= cnt_b_q) begin
          ek_d = '0;
        end else begin
          tre  = 1'b1;
          tra1 = tab_addr(1'b1, jb_q);
        end
      end
      S_P_LDB: begin
        // hold this B term for the whole pass over A
        bhc_d = trd1_q.c;
        bhe_d = trd1_q.e;
        xi_d  = '0;
        yi_d  = '0;
        mn_d  = '0;
        xn_d  = pc_q;
        yn_d  = NW'(cnt_a_q);
        cap_d = NW'(RESULT_TERMS);
        jb_d  = jb_q + 1'b1;
      end
      S_M_RD: begin
        if (!x_av && !y_av) begin
          pc_d   = mn_q;
          bank_d = ~bank_q;
          ek_d   = '0;
        end else begin
          tre = 1'b1;
          pre = 1'b1;
          pra = {bank_q, xi_q[PAW-1:0]};
          if (mul_q) begin
            tra0 = tab_addr(1'b0, yi_q[CW-1:0]);
          end else begin
            tra0 = tab_addr(1'b0, xi_q[CW-1:0]);
            tra1 = tab_addr(1'b1, yi_q[CW-1:0]);
          end
        end
      end
      S_M_MUL: begin
        prod_d = 64'($signed(trd0_q.c)) * 64'($signed(bhc_q));
      end
      S_M_RND: begin
        if (mul_q) begin
          xc_d = prd_q.c;
          xe_d = prd_q.e;
          yc_d = yc_mul;
          ye_d = {trd0_q.e[EXP_W-1], trd0_q.e} + {bhe_q[EXP_W-1], bhe_q};
        end else begin
          xc_d = trd0_q.c;
          xe_d = {trd0_q.e[EXP_W-1], trd0_q.e};
          yc_d = neg_q ? neg_b : trd1_q.c;
          ye_d = {trd1_q.e[EXP_W-1], trd1_q.e};
        end
      end
      S_M_EV: begin
        if (ev_keep) begin
          pwe  = 1'b1;
          pwa  = {~bank_q, mn_q[PAW-1:0]};
          pwd  = '{c: ev_c, e: ev_e};
          mn_d = mn_q + 1'b1;
        end
        if (take_x || take_both) xi_d = xi_q + 1'b1;
        if (!take_x) yi_d = yi_q + 1'b1;
      end
      S_E_RD: begin
        pre = 1'b1;
        pra = {bank_q, ek_q[PAW-1:0]};
      end
      S_E_OUT: begin
        if (ofree) begin
          oload = 1'b1;
          if (pc_q == '0) begin
            ocoef_d = '0;
            oexp_d  = '0;
            olast_d = 1'b1;
            ostat_d = STAT_ZERO;
          end else begin
            ocoef_d = prd_q.c;
            oexp_d  = prd_q.e;
            olast_d = NW'(ek_q + 1'b1) == pc_q;
            ostat_d = STAT_TERM;
            ek_d    = ek_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (twe) tab_mem[twa] <= twd;
    if (tre) begin
      trd0_q <= tab_mem[tra0];
      trd1_q <= tab_mem[tra1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwe) prod_mem[pwa] <= pwd;
    if (pre) prd_q <= prod_mem[pra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      bank_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      bank_q  <= bank_d;
      if (oload) ovld_q <= 1'b1;
      else if (m_axis_tready) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    tsel_q <= tsel_d;  lc_q <= lc_d;  le_q <= le_d;  li_q <= li_d;  lk_q <= lk_d;
    jb_q <= jb_d;  stat_q <= stat_d;  mul_q <= mul_d;  neg_q <= neg_d;
    xi_q <= xi_d;  yi_q <= yi_d;  mn_q <= mn_d;  xn_q <= xn_d;  yn_q <= yn_d;
    cap_q <= cap_d;  pc_q <= pc_d;  ek_q <= ek_d;
    bhc_q <= bhc_d;  bhe_q <= bhe_d;  xc_q <= xc_d;  xe_q <= xe_d;
    yc_q <= yc_d;  ye_q <= ye_d;  prod_q <= prod_d;
    ocoef_q <= ocoef_d;  oexp_q <= oexp_d;  olast_q <= olast_d;  ostat_q <= ostat_d;
  end

endmodule
